### src/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the sobel edge magnitude block
// register indexes, output mode codes, pixel word and result bundle types
// ----------------------------------------------------------------------------
package sem_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_FOUR   = 2'd3;

  // output mode codes (the spare code acts as combined)
  localparam logic [1:0] MODE_COMB = 2'd0;
  localparam logic [1:0] MODE_HORZ = 2'd1;
  localparam logic [1:0] MODE_VERT = 2'd2;

  // reset values of the configuration registers
  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [11:0] RST_HEIGHT = 12'd480;

  // result queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // one pixel, four bytes, channel 0 in the low byte
  typedef logic [31:0] pix_t;

  // per-beat emission flags
  typedef struct packed {
    logic emit_a;  // centre of window, position (r-1, c-1)
    logic emit_b;  // right border of the row above, (r-1, c)
    logic emit_c;  // bottom row pass-through, (r, c)
    logic full;    // window fully interior, filter applies
  } flags_t;

  // up to three results caused by one input beat
  typedef struct packed {
    pix_t [2:0]  pix;   // index 0: emit_a, 1: emit_b, 2: emit_c
    logic [11:0] row;   // row of the input beat
    logic [2:0]  mask;  // which results are present
  } bundle_t;

endpackage

### src/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: streaming 3x3 sobel edge detector, up to three lanes
// line memory of two rows, window registers, per-channel lanes, result queue
// ----------------------------------------------------------------------------
// path: each input beat passes stage b, stage c and the result queue before its results are offered
// throughput: one pixel per cycle while in_stall is low; first-row pixels yield no
//   result and a bottom-row pixel yields up to three, so along the bottom row the
//   single output port holds the input back through in_stall
// reset: registers return to 640x480 combined grayscale, counters, window and
//   result queue clear; the line memory is not cleared and needs no sweep
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_chan0,
  input  logic [7:0]                    in_chan1,
  input  logic [7:0]                    in_chan2,
  input  logic [7:0]                    in_chan3,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_out0,
  output logic [7:0]                    out_out1,
  output logic [7:0]                    out_out2,
  output logic [7:0]                    out_out3,
  output logic [11:0]                   out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
  output logic                          out_run_last,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [11:0]                   cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);

  // configuration registers
  logic [10:0] width_r;
  logic [11:0] height_r;
  logic [1:0]  mode_r;
  logic        four_r;
  logic        cfg_we, restart;

  // frame position
  logic [COL_W-1:0]  col_r;
  logic [11:0]       row_r;
  logic [WCNT_W-1:0] w_eff, w_last;
  logic [11:0]       h_eff, h_last;
  logic              c_last, r_last, acc;
  sem_pkg::pix_t     cur_pack;
  sem_pkg::flags_t   a_flags;

  // stage b
  logic              vb_r;
  sem_pkg::pix_t     b_cur_r;
  logic [11:0]       b_row_r;
  logic [COL_W-1:0]  b_col_r;
  sem_pkg::flags_t   b_flags_r;
  logic [63:0]       rd_r;
  sem_pkg::pix_t     up1, up2;
  sem_pkg::pix_t     win_r [6];

  // stage c
  logic              vc_r;
  sem_pkg::pix_t     c_center_r, c_up1_r, c_cur_r;
  logic [11:0]       c_row_r;
  logic [COL_W-1:0]  c_col_r;
  sem_pkg::flags_t   c_flags_r;
  logic [2:0][7:0]   lane_edge;
  sem_pkg::pix_t     merged;
  sem_pkg::bundle_t  bnd;
  logic              push;

  logic [sem_pkg::QCNT_W-1:0] q_count;
  sem_pkg::pix_t              q_pix;

  // line memory: {row r-2, row r-1} per column
  logic [63:0] line_mem [MAX_WIDTH];

  // configuration port
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        sem_pkg::REG_WIDTH,
        sem_pkg::REG_HEIGHT,
        sem_pkg::REG_MODE,
        sem_pkg::REG_FOUR: restart = 1'b1;
        default:           restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sem_pkg::RST_WIDTH;
      height_r <= sem_pkg::RST_HEIGHT;
      mode_r   <= sem_pkg::MODE_COMB;
      four_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sem_pkg::REG_WIDTH:  width_r  <= cfg_data[10:0];
        sem_pkg::REG_HEIGHT: height_r <= cfg_data;
        sem_pkg::REG_MODE:   mode_r   <= cfg_data[1:0];
        sem_pkg::REG_FOUR:   four_r   <= cfg_data[0];
        default:             width_r  <= width_r;
      endcase
    end
  end

  // clamped frame size and stage a decode
  always_comb begin
    if (width_r < 11'd3)
      w_eff = WCNT_W'(3);
    else if (int'(width_r) > MAX_WIDTH)
      w_eff = WCNT_W'(MAX_WIDTH);
    else
      w_eff = WCNT_W'(width_r);
    h_eff  = (height_r < 12'd3) ? 12'd3 : height_r;
    w_last = w_eff - 1'b1;
    h_last = h_eff - 12'd1;
    c_last = WCNT_W'(col_r) == w_last;
    r_last = row_r == h_last;

    a_flags.emit_a = (row_r != 12'd0) && (col_r != '0);
    a_flags.full   = (row_r >= 12'd2) && (WCNT_W'(col_r) >= WCNT_W'(2));
    a_flags.emit_b = (row_r != 12'd0) && c_last;
    a_flags.emit_c = r_last;

    cur_pack = four_r ? {in_chan3, in_chan2, in_chan1, in_chan0} : {24'd0, in_chan0};

    // room for everything in flight plus this beat
    in_stall = (q_count + sem_pkg::QCNT_W'(vb_r) + sem_pkg::QCNT_W'(vc_r))
               >= sem_pkg::QCNT_W'(sem_pkg::QDEPTH);
    acc      = in_valid && !in_stall;
  end

  // column and row counters
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= 12'd0;
    end else if (acc) begin
      if (c_last) begin
        col_r <= '0;
        row_r <= r_last ? 12'd0 : row_r + 12'd1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // line memory: read at stage a, write back at stage b
  always_ff @(posedge clk) begin
    if (acc)  rd_r <= line_mem[col_r];
    if (vb_r) line_mem[b_col_r] <= {up1, b_cur_r};
  end

  // stage b valid
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= acc;
  end

  // stage b payload
  always_ff @(posedge clk) begin
    if (acc) begin
      b_cur_r   <= cur_pack;
      b_row_r   <= row_r;
      b_col_r   <= col_r;
      b_flags_r <= a_flags;
    end
  end

  assign up1 = rd_r[31:0];
  assign up2 = rd_r[63:32];

  // window registers: two previous columns of the three rows
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (vb_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up2;
      win_r[4] <= up1;
      win_r[5] <= b_cur_r;
    end
  end

  // channel lanes
  for (genvar ln = 0; ln < 3; ln++) begin : g_lane
    sem_lane u_lane (
      .clk       (clk),
      .mode      (mode_r),
      .left_col  ({win_r[2][8*ln +: 8], win_r[1][8*ln +: 8], win_r[0][8*ln +: 8]}),
      .top_mid   (win_r[3][8*ln +: 8]),
      .bot_mid   (win_r[5][8*ln +: 8]),
      .right_col ({b_cur_r[8*ln +: 8], up1[8*ln +: 8], up2[8*ln +: 8]}),
      .edge_val  (lane_edge[ln])
    );
  end

  // stage c valid
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
  end

  // stage c payload
  always_ff @(posedge clk) begin
    if (vb_r) begin
      c_center_r <= win_r[4];
      c_up1_r    <= up1;
      c_cur_r    <= b_cur_r;
      c_row_r    <= b_row_r;
      c_col_r    <= b_col_r;
      c_flags_r  <= b_flags_r;
    end
  end

  // merge lanes into the result bundle
  always_comb begin
    merged = {c_center_r[31:24],
              four_r ? lane_edge[2] : 8'd0,
              four_r ? lane_edge[1] : 8'd0,
              lane_edge[0]};
    bnd.pix[0] = c_flags_r.full ? merged : c_center_r;
    bnd.pix[1] = c_up1_r;
    bnd.pix[2] = c_cur_r;
    bnd.row    = c_row_r;
    bnd.mask   = {c_flags_r.emit_c, c_flags_r.emit_b, c_flags_r.emit_a};
    push       = vc_r && (bnd.mask != 3'b000);
  end

  sem_outq #(
    .COL_W (COL_W)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_bnd  (bnd),
    .push_col  (c_col_r),
    .count     (q_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (q_pix),
    .out_row   (out_row),
    .out_col   (out_col),
    .run_last  (out_run_last)
  );

  assign out_out0 = q_pix[7:0];
  assign out_out1 = q_pix[15:8];
  assign out_out2 = q_pix[23:16];
  assign out_out3 = q_pix[31:24];

endmodule

### src/sem_lane.sv
// ----------------------------------------------------------------------------
// sem_lane: one channel of the 3x3 sobel core
// forms capped gx and gy, registers them, then magnitude, saturate and invert
// ----------------------------------------------------------------------------
module sem_lane (
  input  logic             clk,
  input  logic [1:0]       mode,
  input  logic [2:0][7:0]  left_col,   // top, middle, bottom
  input  logic [7:0]       top_mid,
  input  logic [7:0]       bot_mid,
  input  logic [2:0][7:0]  right_col,  // top, middle, bottom
  output logic [7:0]       edge_val
);

  logic [9:0]         lx_sum, rx_sum, ty_sum, by_sum;
  logic signed [11:0] gx, gy, gx_cap, gy_cap;
  logic signed [11:0] gx_r, gy_r;
  logic signed [11:0] gx_neg, gy_neg;
  logic [10:0]        ax, ay;
  logic [11:0]        s;
  logic [7:0]         sat;

  // weighted column and row sums, weights 1,2,1
  always_comb begin
    lx_sum = {2'b00, left_col[0]} + {1'b0, left_col[1], 1'b0} + {2'b00, left_col[2]};
    rx_sum = {2'b00, right_col[0]} + {1'b0, right_col[1], 1'b0} + {2'b00, right_col[2]};
    ty_sum = {2'b00, left_col[0]} + {1'b0, top_mid, 1'b0} + {2'b00, right_col[0]};
    by_sum = {2'b00, left_col[2]} + {1'b0, bot_mid, 1'b0} + {2'b00, right_col[2]};
    gx     = $signed({2'b00, lx_sum}) - $signed({2'b00, rx_sum});
    gy     = $signed({2'b00, ty_sum}) - $signed({2'b00, by_sum});
    // cap from above only
    gx_cap = (gx > 12'sd255) ? 12'sd255 : gx;
    gy_cap = (gy > 12'sd255) ? 12'sd255 : gy;
  end

  // gradient register
  always_ff @(posedge clk) begin
    gx_r <= gx_cap;
    gy_r <= gy_cap;
  end

  // magnitude, mode select, saturate, invert
  always_comb begin
    gx_neg = -gx_r;
    gy_neg = -gy_r;
    ax     = gx_r[11] ? gx_neg[10:0] : gx_r[10:0];
    ay     = gy_r[11] ? gy_neg[10:0] : gy_r[10:0];
    case (mode)
      sem_pkg::MODE_HORZ: s = {1'b0, ax};
      sem_pkg::MODE_VERT: s = {1'b0, ay};
      default:            s = {1'b0, ax} + {1'b0, ay};
    endcase
    sat      = (s > 12'd255) ? 8'hFF : s[7:0];
    edge_val = 8'hFF - sat;
  end

endmodule

### src/sem_outq.sv
// ----------------------------------------------------------------------------
// sem_outq: result bundle queue and serializer
// holds bundles of up to three results and sends them one beat at a time
// ----------------------------------------------------------------------------
module sem_outq #(
  parameter int COL_W = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  sem_pkg::bundle_t            push_bnd,
  input  logic [COL_W-1:0]            push_col,
  output logic [sem_pkg::QCNT_W-1:0]  count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sem_pkg::pix_t               out_pix,
  output logic [11:0]                 out_row,
  output logic [COL_W-1:0]            out_col,
  output logic                        run_last
);

  sem_pkg::bundle_t             q_r    [sem_pkg::QDEPTH];
  logic [COL_W-1:0]             qcol_r [sem_pkg::QDEPTH];
  logic [sem_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [sem_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2:0]                   done_r, done_nxt;
  sem_pkg::bundle_t             head;
  logic [COL_W-1:0]             head_col;
  logic [2:0]                   pending, pick;
  logic                         take, pop;

  // head selection: lowest pending result goes first
  always_comb begin
    head     = q_r[rd_ptr_r];
    head_col = qcol_r[rd_ptr_r];
    pending  = head.mask & ~done_r;
    if (pending[0]) begin
      pick    = 3'b001;
      out_pix = head.pix[0];
      out_row = head.row - 12'd1;
      out_col = head_col - 1'b1;
    end else if (pending[1]) begin
      pick    = 3'b010;
      out_pix = head.pix[1];
      out_row = head.row - 12'd1;
      out_col = head_col;
    end else begin
      pick    = 3'b100;
      out_pix = head.pix[2];
      out_row = head.row;
      out_col = head_col;
    end
    run_last  = (pending & ~pick) == 3'b000;
    out_valid = cnt_r != '0;
    take      = out_valid && !out_stall;
    pop       = take && run_last;
    done_nxt  = pop ? 3'b000 : (take ? (done_r | pick) : done_r);
    cnt_nxt   = cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    count     = cnt_r;
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      done_r   <= 3'b000;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r]    <= push_bnd;
      qcol_r[wr_ptr_r] <= push_col;
    end
  end

endmodule

### tb/sv/sobel_edge_checker.sv
// ----------------------------------------------------------------------------
// sobel_edge_checker: result predictor and scoreboard for sobel_edge_magnitude
// watches the configuration, pixel and result channels, keeps its own copy of
// the line stores, window and frame counters, predicts every result beat and
// compares it field by field, in order, with what the block emits
// ----------------------------------------------------------------------------
module sobel_edge_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_chan0,
  input  logic [7:0]                    in_chan1,
  input  logic [7:0]                    in_chan2,
  input  logic [7:0]                    in_chan3,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_out0,
  input  logic [7:0]                    out_out1,
  input  logic [7:0]                    out_out2,
  input  logic [7:0]                    out_out3,
  input  logic [11:0]                   out_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]  out_col,
  input  logic                          out_run_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [11:0]                   cfg_data,
  output int                            fail_cnt,
  output int                            pend_cnt,
  output int                            result_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COL_W = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [7:0]       out0;
    logic [7:0]       out1;
    logic [7:0]       out2;
    logic [7:0]       out3;
    logic [11:0]      row;
    logic [COL_W-1:0] col;
    logic             last;
  } pixel_result_t;

  // results predicted but not yet seen, oldest first
  pixel_result_t edge_results_q[$];

  // shadow of the block: two rows above, two previous columns, frame position
  sem_pkg::pix_t row_above2 [MAX_WIDTH];
  sem_pkg::pix_t row_above1 [MAX_WIDTH];
  sem_pkg::pix_t win [6];
  int            row_cnt;
  int            col_cnt;
  logic [10:0]   width_reg;
  logic [11:0]   height_reg;
  logic [1:0]    mode_reg;
  logic          four_reg;
  int            mismatches;
  int            compared;

  // restart of the frame on reset and on every register write
  task automatic restart_frame();
    begin
      for (int i = 0; i < 6; i++) win[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
    end
  endtask

  // inverted, saturated gradient of one byte lane; px[row][col], top left first
  function automatic logic [7:0] sobel_byte(input sem_pkg::pix_t [2:0][2:0] px,
                                            input int ch);
    int a [3][3];
    int gx;
    int gy;
    int s;
    begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          a[i][j] = int'(px[i][j][8*ch +: 8]);
      gx = a[0][0] + 2 * a[1][0] + a[2][0] - a[0][2] - 2 * a[1][2] - a[2][2];
      gy = a[0][0] + 2 * a[0][1] + a[0][2] - a[2][0] - 2 * a[2][1] - a[2][2];
      // cap from above only, a large negative gradient keeps its size
      if (gx > 255) gx = 255;
      if (gy > 255) gy = 255;
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      case (mode_reg)
        sem_pkg::MODE_HORZ: s = gx;
        sem_pkg::MODE_VERT: s = gy;
        default:            s = gx + gy;
      endcase
      if (s > 255) s = 255;
      return 8'(255 - s);
    end
  endfunction

  function automatic pixel_result_t make_result(input sem_pkg::pix_t p, input int r,
                                                input int c);
    pixel_result_t m;
    begin
      m.out0 = p[7:0];
      m.out1 = p[15:8];
      m.out2 = p[23:16];
      m.out3 = p[31:24];
      m.row  = r[11:0];
      m.col  = c[COL_W-1:0];
      m.last = 1'b0;
      return m;
    end
  endfunction

  // one accepted pixel: emit the centre, the right border above, the bottom row
  task automatic predict_pixel(input sem_pkg::pix_t raw);
    int                       w;
    int                       h;
    int                       r;
    int                       c;
    int                       n;
    int                       nch;
    sem_pkg::pix_t            cur;
    sem_pkg::pix_t            up1;
    sem_pkg::pix_t            up2;
    sem_pkg::pix_t            res;
    sem_pkg::pix_t [2:0][2:0] px;
    pixel_result_t            batch [3];
    begin
      w = int'(width_reg);
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(height_reg);
      if (h < 3) h = 3;
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      r = row_cnt;
      c = col_cnt;
      n = 0;
      cur = four_reg ? raw : {24'd0, raw[7:0]};
      up1 = row_above1[c];
      up2 = row_above2[c];

      if (r >= 1 && c >= 1) begin
        res = win[4];
        if (r >= 2 && c >= 2) begin
          px[0][0] = win[0]; px[1][0] = win[1]; px[2][0] = win[2];
          px[0][1] = win[3]; px[1][1] = win[4]; px[2][1] = win[5];
          px[0][2] = up2;    px[1][2] = up1;    px[2][2] = cur;
          // fourth byte passes through, filtered lanes replaced
          res = {win[4][31:24], 24'd0};
          nch = four_reg ? 3 : 1;
          for (int ch = 0; ch < nch; ch++) res[8*ch +: 8] = sobel_byte(px, ch);
        end
        batch[n] = make_result(res, r - 1, c - 1);
        n++;
      end
      if (r >= 1 && c == w - 1) begin
        batch[n] = make_result(up1, r - 1, c);
        n++;
      end
      if (r == h - 1) begin
        batch[n] = make_result(cur, r, c);
        n++;
      end
      for (int k = 0; k < n; k++) begin
        if (k == n - 1) batch[k].last = 1'b1;
        edge_results_q.push_back(batch[k]);
      end

      // shift line stores and window
      row_above2[c] = up1;
      row_above1[c] = cur;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = up2;
      win[4] = up1;
      win[5] = cur;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got,
                             input int r, input int c);
    begin
      if (want != got) begin
        $display("%0t: %s mismatch at row %0d col %0d, expected %0d actual %0d",
                 $time, name, r, c, want, got);
        mismatches++;
      end
    end
  endtask

  // compare one result beat against the oldest prediction
  task automatic check_result();
    pixel_result_t want;
    begin
      compared++;
      if (edge_results_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual row %0d col %0d",
                 $time, out_row, out_col);
        mismatches++;
      end else begin
        want = edge_results_q.pop_front();
        check_field("out0", want.out0, out_out0, want.row, want.col);
        check_field("out1", want.out1, out_out1, want.row, want.col);
        check_field("out2", want.out2, out_out2, want.row, want.col);
        check_field("out3", want.out3, out_out3, want.row, want.col);
        check_field("out_row", want.row, out_row, want.row, want.col);
        check_field("out_col", want.col, out_col, want.row, want.col);
        check_field("out_run_last", want.last, out_run_last, want.row, want.col);
      end
    end
  endtask

  // all channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = sem_pkg::RST_WIDTH;
      height_reg = sem_pkg::RST_HEIGHT;
      mode_reg   = sem_pkg::MODE_COMB;
      four_reg   = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above1[i] = '0;
        row_above2[i] = '0;
      end
      restart_frame();
      edge_results_q.delete();
    end else begin
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sem_pkg::REG_WIDTH:  width_reg  = cfg_data[10:0];
          sem_pkg::REG_HEIGHT: height_reg = cfg_data;
          sem_pkg::REG_MODE:   mode_reg   = cfg_data[1:0];
          sem_pkg::REG_FOUR:   four_reg   = cfg_data[0];
          default:             ;
        endcase
        restart_frame();
      end
      // pixel beat
      if (in_valid && !in_stall)
        predict_pixel({in_chan3, in_chan2, in_chan1, in_chan0});
      // result beat
      if (out_valid && !out_stall)
        check_result();
    end
    fail_cnt   <= mismatches;
    pend_cnt   <= edge_results_q.size();
    result_cnt <= compared;
  end

endmodule

### tb/sv/tb_sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude: regression bench for the streaming sobel detector
// drives directed frames for saturation, border and wrap behavior, then random
// frame settings and pixel textures with idle bursts on both channels and a
// long output hold-off; the checker scores every result
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_WIDTH    = 1024;
  localparam int         LIMIT_NS     = 2_000_000;
  localparam int         HOLD_CYCLES  = 70;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         RAND_PIXELS  = 80;

  typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_FLAT, TEX_SATURATE} texture_e;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    in_chan0;
  logic [7:0]                    in_chan1;
  logic [7:0]                    in_chan2;
  logic [7:0]                    in_chan3;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_out0;
  logic [7:0]                    out_out1;
  logic [7:0]                    out_out2;
  logic [7:0]                    out_out3;
  logic [11:0]                   out_row;
  logic [$clog2(MAX_WIDTH)-1:0]  out_col;
  logic                          out_run_last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index;
  logic [11:0]                   cfg_data;

  int fail_cnt;
  int pend_cnt;
  int result_cnt;

  bit idle_on;
  int hold_req;
  int pixels_sent;
  int settings_cnt;

  sobel_edge_magnitude #(.MAX_WIDTH(MAX_WIDTH)) uut (.*);

  sobel_edge_checker #(.MAX_WIDTH(MAX_WIDTH)) scoreboard (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("%0t: run did not finish in time", $time);
    $display("sobel_edge_magnitude regression: fail");
    $finish;
  end

  // result side pacing: random stall bursts plus the requested long hold-off
  initial begin : rx_pace
    int hold_left;
    int burst_left;
    int hold_seen;
    hold_left  = 0;
    burst_left = 0;
    hold_seen  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one register write beat
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic set_frame(input logic [10:0] w, input logic [11:0] h,
                           input logic [1:0] mode, input logic four);
    begin
      write_reg(sem_pkg::REG_WIDTH, {1'b0, w});
      write_reg(sem_pkg::REG_HEIGHT, h);
      write_reg(sem_pkg::REG_MODE, {10'd0, mode});
      write_reg(sem_pkg::REG_FOUR, {11'd0, four});
      settings_cnt++;
    end
  endtask

  // one pixel beat, with an optional idle burst in front of it
  task automatic push_pixel(input sem_pkg::pix_t p);
    int gap;
    begin
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_chan0 <= p[7:0];
      in_chan1 <= p[15:8];
      in_chan2 <= p[23:16];
      in_chan3 <= p[31:24];
      do @(posedge clk); while (in_stall);
      pixels_sent++;
    end
  endtask

  // let every predicted result drain, then cover beats that cause none
  task automatic wait_idle();
    begin
      @(negedge clk);
      in_valid <= 1'b0;
      while (pend_cnt != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  function automatic sem_pkg::pix_t gen_pixel(input texture_e tex,
                                              input sem_pkg::pix_t base);
    sem_pkg::pix_t p;
    int            v;
    begin
      p = '0;
      for (int b = 0; b < 4; b++) begin
        case (tex)
          TEX_NOISE:    v = $urandom_range(0, 255);
          TEX_SMOOTH:   v = int'(base[8*b +: 8]) + $urandom_range(0, 24);
          TEX_FLAT:     v = int'(base[8*b +: 8]);
          default:      v = ($urandom_range(0, 1) == 1) ? 255 : 0;
        endcase
        if (v > 255) v = 255;
        p[8*b +: 8] = v[7:0];
      end
      return p;
    end
  endfunction

  // program a setting and stream npix pixels of one texture
  task automatic run_setting(input logic [10:0] w, input logic [11:0] h,
                             input logic [1:0] mode, input logic four,
                             input int npix, input texture_e tex);
    sem_pkg::pix_t base;
    begin
      base = {8'($urandom_range(0, 231)), 8'($urandom_range(0, 231)),
              8'($urandom_range(0, 231)), 8'($urandom_range(0, 231))};
      set_frame(w, h, mode, four);
      for (int k = 0; k < npix; k++) push_pixel(gen_pixel(tex, base));
      wait_idle();
    end
  endtask

  initial begin : stimulus
    logic [10:0]   w_reg;
    logic [11:0]   h_reg;
    int            w_eff;
    int            h_eff;
    int            npix;
    int            rand_pixels;
    texture_e      tex;
    sem_pkg::pix_t p;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_chan0     = 8'd0;
    in_chan1     = 8'd0;
    in_chan2     = 8'd0;
    in_chan3     = 8'd0;
    cfg_valid    = 1'b0;
    cfg_index    = sem_pkg::REG_WIDTH;
    cfg_data     = 12'd0;
    idle_on      = 1'b0;
    hold_req     = 0;
    pixels_sent  = 0;
    settings_cnt = 0;
    rand_pixels  = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // 3x3 from clamped width and height, four channels: the centre saturates
    // with a large positive gx, a large negative gx and a large negative gy
    set_frame(11'd0, 12'd2, sem_pkg::MODE_COMB, 1'b1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        p[7:0]   = (c == 0) ? 8'hFF : 8'h00;
        p[15:8]  = (c == 2) ? 8'hFF : 8'h00;
        p[23:16] = (r == 2) ? 8'hFF : 8'h00;
        p[31:24] = 8'((r * 3 + c) * 30);
        push_pixel(p);
      end
    wait_idle();

    // grayscale, vertical only, mild gradient; upper lanes must read zero,
    // and the stream runs past the frame end into the next frame
    set_frame(11'd3, 12'd3, sem_pkg::MODE_VERT, 1'b0);
    for (int k = 0; k < 15; k++) begin
      p = {8'hFF, 8'hFF, 8'hFF, ((k % 9) < 3) ? 8'd20 : 8'd0};
      push_pixel(p);
    end
    wait_idle();

    // random settings, mostly small frames, some clamped and some partial
    idle_on = 1'b1;
    while (rand_pixels < RAND_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w_reg = 11'($urandom_range(0, 2));
        1:       w_reg = 11'($urandom_range(9, 16));
        default: w_reg = 11'($urandom_range(3, 8));
      endcase
      h_reg = ($urandom_range(0, 6) == 0) ? 12'($urandom_range(0, 2))
                                          : 12'($urandom_range(3, 5));
      w_eff = (w_reg < 3) ? 3 : int'(w_reg);
      h_eff = (h_reg < 3) ? 3 : int'(h_reg);
      npix  = w_eff * h_eff * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) npix = $urandom_range(1, w_eff * h_eff - 1);
      if (npix > RAND_PIXELS - rand_pixels) npix = RAND_PIXELS - rand_pixels;
      tex     = texture_e'($urandom_range(0, 3));
      idle_on = ($urandom_range(0, 3) != 0);
      run_setting(w_reg, h_reg, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  npix, tex);
      rand_pixels += npix;
    end

    // long result hold-off while pixels keep coming at full rate
    idle_on = 1'b0;
    hold_req++;
    run_setting(11'd6, 12'd4, sem_pkg::MODE_COMB, 1'b1, 30, TEX_SMOOTH);

    // closing frames with no idling on either side
    run_setting(11'd4, 12'd3, sem_pkg::MODE_VERT, 1'b1, 36, TEX_SMOOTH);

    while (pend_cnt != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("summary: %0d pixels over %0d frame settings, %0d result beats compared",
             pixels_sent, settings_cnt, result_cnt);
    $display("summary: widths 3 to 16 with clamping, random mode codes, gray and four"
             , " lanes, wraps, partial frames, idle bursts and a long output hold-off");
    if (fail_cnt == 0 && pend_cnt == 0)
      $display("sobel_edge_magnitude regression: pass");
    else
      $display("sobel_edge_magnitude regression: fail");
    $finish;
  end

endmodule

### sobel_edge_magnitude.f
src/sem_pkg.sv
src/sem_lane.sv
src/sem_outq.sv
src/sobel_edge_magnitude.sv
tb/sv/sobel_edge_checker.sv
tb/sv/tb_sobel_edge_magnitude.sv
